### rtl/core/assert_macros.svh
// Assertion helpers, clocked on aclk and muted while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define BRP_ASSERT_IMP(lbl, ante, cons, msg) \
    `BRP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/core/brp_pkg.sv
package brp_pkg;

    typedef enum logic [0:0] {
        OP_RENDER = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    localparam int DEFAULT_WIDTH  = 320;
    localparam int DEFAULT_HEIGHT = 240;
    localparam int SRC_W          = 256;
    localparam int SRC_H          = 192;
    localparam int ZOOM_W         = 320;
    localparam int ZOOM_H         = 240;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [4:0] FLASH_LIMIT = 5'd16;
    localparam int ATTR_BRIGHT = 6;
    localparam int ATTR_FLASH  = 7;

    localparam logic [1:0] SIZE_ONE = 2'd1;
    localparam logic [1:0] SIZE_TWO = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified cell line, ready for the pixel sequencer
    typedef struct packed {
        logic [3:0]  ink;
        logic [3:0]  paper;
        logic [7:0]  pixels;
        logic [4:0]  char_col;
        logic [12:0] bitmap_address;
        logic [7:0]  y_pos;
        logic [1:0]  rect_height;
    } cell_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

### rtl/core/bitmap_attribute_pixel_renderer.sv
// channel  | dir | data
// s_       | in  | tuser: opcode; tdata: char_row, char_col, cell_line, pixel_byte, attr_byte
// m_       | out | tdata: x_pos .. bitmap_address; tlast: last_pixel
// cfg_     | in  | zoom_enable, written when cfg_wr_en is high
//
// A cell line yields eight pixels, one per cycle from the back-end sequencer unless
// m_tready stalls it; a frame tick only steps the flash counter and is never queued.
// A render item's first pixel passes the queue, the current-cell register and the output register.
// A 2-entry queue lets the front take items while the back end is busy or stalled.
// Synchronous active-low reset clears flash state, queue and output valid.
module bitmap_attribute_pixel_renderer #(
    parameter int DISPLAY_WIDTH  = brp_pkg::DEFAULT_WIDTH,
    parameter int DISPLAY_HEIGHT = brp_pkg::DEFAULT_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [4:0] char_row, [9:5] char_col, [12:10] cell_line, [20:13] pixel_byte,
    // [28:21] attr_byte, [31:29] zero
    input  logic [brp_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [8:0] x_pos, [16:9] y_pos, [18:17] rect_width, [20:19] rect_height,
    // [24:21] color_index, [37:25] bitmap_address, [39:38] zero
    output logic [brp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    `include "assert_macros.svh"

    logic             zoom_reg, zoom_next;
    logic             push, pop;
    brp_pkg::cell_t   push_cell, head_cell;
    brp_pkg::q_stat_t q_stat;

    assign zoom_next = cfg_wr_en ? cfg_wr_data : zoom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg <= 1'b0;
        end else begin
            zoom_reg <= zoom_next;
        end
    end

    brp_front #(
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .zoom      (zoom_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_stat.full),
        .push      (push),
        .push_cell (push_cell)
    );

    brp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cell (push_cell),
        .pop       (pop),
        .head_cell (head_cell),
        .stat      (q_stat)
    );

    brp_back #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .zoom      (zoom_reg),
        .q_empty   (q_stat.empty),
        .head_cell (head_cell),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // only render items reach the queue
    `BRP_ASSERT_IMP(a_push_is_render, push, s_tvalid && s_tready && s_tuser == brp_pkg::OP_RENDER, "queue push without accepted render item")
    // the back end never pops an empty queue
    `BRP_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty && q_stat.pop, "pop on empty queue")
    // input backpressure comes only from a full queue
    `BRP_ASSERT_IMP(a_stall_full, !s_tready, q_stat.count == brp_pkg::QCNT_W'(brp_pkg::QUEUE_DEPTH), "input stalled with room in queue")

endmodule

### rtl/core/brp_front.sv
module brp_front #(
    parameter int DISPLAY_HEIGHT = brp_pkg::DEFAULT_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          zoom,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [brp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          push,
    output brp_pkg::cell_t                push_cell
);

    localparam logic [7:0] Y_OFS_ZOOM = 8'((DISPLAY_HEIGHT - brp_pkg::ZOOM_H) / 2);
    localparam logic [7:0] Y_OFS_NAT  = 8'((DISPLAY_HEIGHT - brp_pkg::SRC_H) / 2);

    logic [4:0] frame_count_reg, frame_count_next;
    logic       flash_phase_reg, flash_phase_next;
    logic [4:0] row, col, fc_inc;
    logic [2:0] line;
    logic [7:0] pix, attr, sy;
    logic [3:0] ink, paper;
    logic       accept, swap;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign row  = s_tdata[4:0];
    assign col  = s_tdata[9:5];
    assign line = s_tdata[12:10];
    assign pix  = s_tdata[20:13];
    assign attr = s_tdata[28:21];

    assign fc_inc = frame_count_reg + 5'd1;

    always_comb begin
        frame_count_next = frame_count_reg;
        flash_phase_next = flash_phase_reg;
        if (accept && s_tuser == brp_pkg::OP_TICK) begin
            if (fc_inc > brp_pkg::FLASH_LIMIT) begin
                frame_count_next = 5'd0;
                flash_phase_next = !flash_phase_reg;
            end else begin
                frame_count_next = fc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= 5'd0;
            flash_phase_reg <= 1'b0;
        end else begin
            frame_count_reg <= frame_count_next;
            flash_phase_reg <= flash_phase_next;
        end
    end

    assign swap  = attr[brp_pkg::ATTR_FLASH] && flash_phase_reg;
    assign ink   = {attr[brp_pkg::ATTR_BRIGHT], swap ? attr[5:3] : attr[2:0]};
    assign paper = {attr[brp_pkg::ATTR_BRIGHT], swap ? attr[2:0] : attr[5:3]};
    assign sy    = {row, line};

    assign push = accept && s_tuser == brp_pkg::OP_RENDER;

    always_comb begin
        push_cell.ink            = ink;
        push_cell.paper          = paper;
        push_cell.pixels         = pix;
        push_cell.char_col       = col;
        push_cell.bitmap_address = {row[4:3], line, row[2:0], col};
        // 5/4 scale: sy + sy/4; the line doubles where sy mod 4 is 3
        if (zoom) begin
            push_cell.y_pos       = sy + {2'b00, sy[7:2]} + Y_OFS_ZOOM;
            push_cell.rect_height = (sy[1:0] == 2'b11) ? brp_pkg::SIZE_TWO
                                                       : brp_pkg::SIZE_ONE;
        end else begin
            push_cell.y_pos       = sy + Y_OFS_NAT;
            push_cell.rect_height = brp_pkg::SIZE_ONE;
        end
    end

endmodule

### rtl/core/brp_queue.sv
module brp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  brp_pkg::cell_t   push_cell,
    input  logic             pop,
    output brp_pkg::cell_t   head_cell,
    output brp_pkg::q_stat_t stat
);

    brp_pkg::cell_t                 mem_reg [brp_pkg::QUEUE_DEPTH];
    logic [brp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [brp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [brp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    localparam logic [brp_pkg::QCNT_W-1:0] DEPTH_C = brp_pkg::QCNT_W'(brp_pkg::QUEUE_DEPTH);
    localparam logic [brp_pkg::QPTR_W-1:0] LAST_P  = brp_pkg::QPTR_W'(brp_pkg::QUEUE_DEPTH - 1);
    localparam logic [brp_pkg::QCNT_W-1:0] CNT_ONE = brp_pkg::QCNT_W'(1);

    assign do_push = push && count_reg != DEPTH_C;
    assign do_pop  = pop && count_reg != '0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cell;
        end
    end

    assign head_cell  = mem_reg[rd_ptr_reg];
    assign stat.push  = do_push;
    assign stat.pop   = do_pop;
    assign stat.full  = count_reg == DEPTH_C;
    assign stat.empty = count_reg == '0;
    assign stat.count = count_reg;

endmodule

### rtl/core/brp_back.sv
module brp_back #(
    parameter int DISPLAY_WIDTH = brp_pkg::DEFAULT_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          zoom,
    input  logic                          q_empty,
    input  brp_pkg::cell_t                head_cell,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    localparam logic [8:0] X_OFS_ZOOM = 9'((DISPLAY_WIDTH - brp_pkg::ZOOM_W) / 2);
    localparam logic [8:0] X_OFS_NAT  = 9'((DISPLAY_WIDTH - brp_pkg::SRC_W) / 2);

    brp_pkg::cell_t              cur_reg, cur_next;
    logic                        busy_reg, busy_next;
    logic [2:0]                  k_reg, k_next;
    logic                        m_valid_reg, m_valid_next;
    logic [brp_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;
    logic                        out_free, emit, at_last;
    logic [7:0]                  sx;
    logic [8:0]                  x_pos;
    logic [1:0]                  rect_width;
    logic [3:0]                  color;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign at_last  = k_reg == 3'd7;
    assign pop      = !q_empty && (!busy_reg || (emit && at_last));

    assign sx = {cur_reg.char_col, k_reg};

    always_comb begin
        if (zoom) begin
            x_pos      = {1'b0, sx} + {3'b000, sx[7:2]} + X_OFS_ZOOM;
            rect_width = (sx[1:0] == 2'b11) ? brp_pkg::SIZE_TWO : brp_pkg::SIZE_ONE;
        end else begin
            x_pos      = {1'b0, sx} + X_OFS_NAT;
            rect_width = brp_pkg::SIZE_ONE;
        end
        // bit 7 goes out first: index 7-k is ~k on three bits
        color = cur_reg.pixels[~k_reg] ? cur_reg.ink : cur_reg.paper;
    end

    always_comb begin
        cur_next     = cur_reg;
        busy_next    = busy_reg;
        k_next       = k_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_last_next  = at_last;
            m_data_next  = {2'b00, cur_reg.bitmap_address, color, cur_reg.rect_height,
                            rect_width, cur_reg.y_pos, x_pos};
            k_next       = k_reg + 3'd1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            cur_next  = head_cell;
            busy_next = 1'b1;
            k_next    = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            k_reg       <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### tb/sv/tb_bitmap_attribute_pixel_renderer.sv
module tb_bitmap_attribute_pixel_renderer;
    import brp_pkg::*;

    localparam int DISP_W     = DEFAULT_WIDTH;
    localparam int DISP_H     = DEFAULT_HEIGHT;
    localparam int DRAIN_WAIT = 12;    // settle time after the last expected pixel
    localparam int IDLE_LIMIT = 3000;  // cycles with no item moving on either side

    typedef struct {
        logic [8:0]  x_pos;
        logic [7:0]  y_pos;
        logic [1:0]  rect_w;
        logic [1:0]  rect_h;
        logic [3:0]  color;
        logic [12:0] addr;
        logic        last;
    } pixel_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // predictor state
    logic       zoom_on   = 1'b0;
    logic [4:0] frame_cnt = '0;
    logic       flash_on  = 1'b0;

    pixel_t pixel_q[$];
    int     errors     = 0;
    int     idle_count = 0;

    // pacing on both sides
    int  send_mode_left = 0;
    bit  send_no_gaps   = 1'b0;
    int  rdy_mode_left  = 0;
    bit  rdy_stalls     = 1'b1;
    int  stall_left     = 0;

    bitmap_attribute_pixel_renderer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int zoom_scale(input int s);
        return (s * 5) / 4;
    endfunction

    task automatic advance_frame();
        frame_cnt = frame_cnt + 5'd1;
        if (frame_cnt > FLASH_LIMIT) begin
            flash_on  = ~flash_on;
            frame_cnt = '0;
        end
    endtask

    task automatic render_cell_line(input logic [4:0] row, input logic [4:0] col,
                                    input logic [2:0] line, input logic [7:0] pix,
                                    input logic [7:0] attr);
        logic [3:0]  ink;
        logic [3:0]  paper;
        logic [3:0]  tmp;
        logic [12:0] addr;
        int          sy;
        int          sx;
        int          ypos;
        int          xpos;
        int          h;
        int          w;
        pixel_t      p;
        ink   = {attr[ATTR_BRIGHT], attr[2:0]};
        paper = {attr[ATTR_BRIGHT], attr[5:3]};
        if (attr[ATTR_FLASH] && flash_on) begin
            tmp   = ink;
            ink   = paper;
            paper = tmp;
        end
        addr = {row[4:3], line, row[2:0], col};
        sy   = int'(row) * 8 + int'(line);
        if (zoom_on) begin
            ypos = zoom_scale(sy) + (DISP_H - ZOOM_H) / 2;
            h    = zoom_scale(sy + 1) - zoom_scale(sy);
        end else begin
            ypos = sy + (DISP_H - SRC_H) / 2;
            h    = 1;
        end
        for (int k = 0; k < 8; k++) begin
            sx = int'(col) * 8 + k;
            if (zoom_on) begin
                xpos = zoom_scale(sx) + (DISP_W - ZOOM_W) / 2;
                w    = zoom_scale(sx + 1) - zoom_scale(sx);
            end else begin
                xpos = sx + (DISP_W - SRC_W) / 2;
                w    = 1;
            end
            p.x_pos  = 9'(xpos);
            p.y_pos  = 8'(ypos);
            p.rect_w = 2'(w);
            p.rect_h = 2'(h);
            p.color  = pix[7-k] ? ink : paper;
            p.addr   = addr;
            p.last   = (k == 7);
            pixel_q.push_back(p);
        end
    endtask

    // to be called right after a rising edge, which the task does not enforce; returns right after the item is taken
    task automatic send_item(input opcode_t op, input logic [4:0] row, input logic [4:0] col,
                             input logic [2:0] line, input logic [7:0] pix,
                             input logic [7:0] attr);
        int gap;
        if (send_mode_left == 0) begin
            send_no_gaps   = ($urandom_range(0, 3) == 0);
            send_mode_left = $urandom_range(20, 80);
        end else begin
            send_mode_left--;
        end
        gap = 0;
        if (!send_no_gaps && $urandom_range(0, 1) == 0)
            gap = pause_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, attr, pix, line, col, row};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_TICK)
            advance_frame();
        else
            render_cell_line(row, col, line, pix, attr);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic set_zoom(input logic val);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        zoom_on = val;
    endtask

    task automatic check_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic extreme_cells();
        send_item(OP_RENDER, 5'd0,  5'd0,  3'd0, 8'h00, 8'h00);
        send_item(OP_RENDER, 5'd23, 5'd31, 3'd7, 8'hFF, 8'hFF);
        send_item(OP_RENDER, 5'd31, 5'd31, 3'd7, 8'hA5, 8'h7F);
        send_item(OP_RENDER, 5'd24, 5'd16, 3'd3, 8'h5A, 8'h40);
        send_item(OP_RENDER, 5'd8,  5'd1,  3'd1, 8'h81, 8'h38);
    endtask

    // corners, bright, rows past the screen and position wrap, both zoom settings
    task automatic test_extremes();
        set_zoom(1'b0);
        extreme_cells();
        set_zoom(1'b1);
        extreme_cells();
        set_zoom(1'b0);
    endtask

    // flashing cells on both flash phases, counter wrap after 17 ticks
    task automatic test_flash();
        repeat (16) send_item(OP_TICK, 5'd0, 5'd0, 3'd0, 8'h00, 8'h00);
        send_item(OP_RENDER, 5'd2, 5'd3, 3'd4, 8'hF0, 8'hC1);
        send_item(OP_TICK, 5'd31, 5'd31, 3'd7, 8'hFF, 8'hFF);
        send_item(OP_RENDER, 5'd2, 5'd3, 3'd4, 8'hF0, 8'hC1);
        send_item(OP_RENDER, 5'd5, 5'd9, 3'd2, 8'h3C, 8'h0A);
        send_item(OP_RENDER, 5'd5, 5'd9, 3'd2, 8'h3C, 8'h87);
        repeat (17) send_item(OP_TICK, 5'd0, 5'd0, 3'd0, 8'h00, 8'h00);
        send_item(OP_RENDER, 5'd5, 5'd9, 3'd2, 8'h3C, 8'h87);
    endtask

    task automatic test_random(input int n_items);
        opcode_t    op;
        logic [4:0] row;
        for (int ph = 0; ph < 4; ph++) begin
            set_zoom(ph[0]);
            for (int i = 0; i < n_items / 4; i++) begin
                op  = ($urandom_range(0, 99) < 20) ? OP_TICK : OP_RENDER;
                row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                  : 5'($urandom_range(0, 23));
                send_item(op, row, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                          8'($urandom), 8'($urandom));
            end
        end
    endtask

    // result side backpressure, with stretches of no stalls
    always @(negedge aclk) begin
        if (rdy_mode_left == 0) begin
            rdy_stalls    = ($urandom_range(0, 2) != 0);
            rdy_mode_left = $urandom_range(50, 300);
        end else begin
            rdy_mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rdy_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = pause_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pixel_t p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                p = pixel_q.pop_front();
                check_field("x_pos",          p.x_pos,  m_tdata[8:0]);
                check_field("y_pos",          p.y_pos,  m_tdata[16:9]);
                check_field("rect_width",     p.rect_w, m_tdata[18:17]);
                check_field("rect_height",    p.rect_h, m_tdata[20:19]);
                check_field("color_index",    p.color,  m_tdata[24:21]);
                check_field("bitmap_address", p.addr,   m_tdata[37:25]);
                check_field("last_pixel",     p.last,   m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_flash();
        test_random(260);
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
